FILE: hw/rtl/microwire_serial_eeprom_macros.svh
// Assertion macros used by the RTL top file.
// MSE_ASSERT checks a property outside reset; MSE_ASSERT_ALWAYS checks it on every edge.
`ifndef MICROWIRE_SERIAL_EEPROM_MACROS_SVH
`define MICROWIRE_SERIAL_EEPROM_MACROS_SVH
`ifndef SYNTHESIS
`define MSE_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
`define MSE_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSE_ASSERT(name, clk, rst_n, prop, msg)
`define MSE_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/mse_pkg.sv
`timescale 1ns / 1ps
package mse_pkg;

    localparam int ADDRESS_BITS_DEF = 6;
    localparam int WORD_W           = 16;
    localparam int WCNT_W           = 5;

    localparam logic [WORD_W-1:0] ERASED_WORD = 16'hffff;
    localparam logic [WCNT_W-1:0] WORD_LEN    = 5'd16;

    // Pin positions in the port byte for both layouts
    localparam int PIN0_CLK = 7;
    localparam int PIN0_CS  = 6;
    localparam int PIN0_DI  = 5;
    localparam int PIN1_CLK = 5;
    localparam int PIN1_CS  = 4;
    localparam int PIN1_DI  = 6;

    // APB register indexes
    localparam logic REG_PIN_LAYOUT = 1'b0;

    typedef enum logic [1:0] {
        OP_MISC  = 2'b00,
        OP_WRITE = 2'b01,
        OP_READ  = 2'b10,
        OP_ERASE = 2'b11
    } t_opcode;

    typedef enum logic [1:0] {
        CTL_EWDS = 2'b00,
        CTL_WRAL = 2'b01,
        CTL_ERAL = 2'b10,
        CTL_EWEN = 2'b11
    } t_control;

endpackage

FILE: hw/rtl/mse_ram.sv
`timescale 1ns / 1ps
module mse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read data on a read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/microwire_serial_eeprom.sv
// Microwire serial EEPROM slave, one port byte per transfer.
// One input transfer per cycle unless the result channel or the erase pass stalls it;
// the result is valid the cycle after acceptance. A read command's first data-out bit
// comes from the word store's registered read port. Reset is synchronous, active low;
// it clears control state, then an erase pass writes all ones to the store, taking no input.
`timescale 1ns / 1ps
`include "microwire_serial_eeprom_macros.svh"
module microwire_serial_eeprom
    import mse_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_port_byte,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_data_out,
    output logic        o_writes_allowed,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH    = 1 << ADDRESS_BITS;
    localparam int CMD_BITS = ADDRESS_BITS + 3;
    localparam int CCNT_W   = $clog2(CMD_BITS + 1);

    // Control state
    logic                    r_pin_layout;
    logic                    r_clr_busy;
    logic [ADDRESS_BITS-1:0] r_clr_addr;
    logic                    r_out_valid;
    logic                    r_clock_before, n_clock_before;
    logic [CCNT_W-1:0]       r_cmd_count,    n_cmd_count;
    logic [WCNT_W-1:0]       r_read_count,   n_read_count;
    logic [WCNT_W-1:0]       r_write_count,  n_write_count;
    logic                    r_write_enable, n_write_enable;
    logic                    r_out_level,    n_out_level;
    logic                    r_rd_load,      n_rd_load;
    // Payload state
    logic [CMD_BITS-1:0]     r_cmd_shift,    n_cmd_shift;
    logic [WORD_W-1:0]       r_read_shift,   n_read_shift;
    logic [WORD_W-1:0]       r_write_shift,  n_write_shift;
    logic [ADDRESS_BITS-1:0] r_write_target, n_write_target;

    logic                    in_accept;
    logic                    pin_clk, pin_cs, pin_di;
    logic                    rise;
    logic [WORD_W-1:0]       eff_read_shift;
    logic                    eff_out_level;
    logic [CMD_BITS-1:0]     cmd_next;
    t_opcode                 cmd_op;
    t_control                cmd_ctl;
    logic [ADDRESS_BITS-1:0] cmd_addr;
    logic                    item_we, item_re;
    logic [ADDRESS_BITS-1:0] item_waddr, item_raddr;
    logic [WORD_W-1:0]       item_wdata;
    logic                    ram_we;
    logic [ADDRESS_BITS-1:0] ram_waddr;
    logic [WORD_W-1:0]       ram_wdata;
    logic [WORD_W-1:0]       ram_rdata;

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = !r_clr_busy && (!r_out_valid || i_out_ready);

    // Pick clock, select and data-in from the port byte
    always_comb begin
        if (r_pin_layout) begin
            pin_clk = i_port_byte[PIN1_CLK];
            pin_cs  = i_port_byte[PIN1_CS];
            pin_di  = i_port_byte[PIN1_DI];
        end else begin
            pin_clk = i_port_byte[PIN0_CLK];
            pin_cs  = i_port_byte[PIN0_CS];
            pin_di  = i_port_byte[PIN0_DI];
        end
    end

    assign rise = pin_cs && !r_clock_before && pin_clk;

    // Forward the store word while a read load is pending
    assign eff_read_shift = r_rd_load ? ram_rdata : r_read_shift;
    assign eff_out_level  = r_rd_load ? ram_rdata[WORD_W-1] : r_out_level;

    // Decode the command as it would stand after taking this bit
    assign cmd_next = {r_cmd_shift[CMD_BITS-2:0], pin_di};
    assign cmd_op   = t_opcode'(cmd_next[ADDRESS_BITS+1:ADDRESS_BITS]);
    assign cmd_addr = cmd_next[ADDRESS_BITS-1:0];
    assign cmd_ctl  = t_control'(cmd_next[ADDRESS_BITS-1:ADDRESS_BITS-2]);

    // Next state for one accepted transfer
    always_comb begin
        n_clock_before = pin_clk;
        n_cmd_count    = r_cmd_count;
        n_cmd_shift    = r_cmd_shift;
        n_read_count   = r_read_count;
        n_read_shift   = eff_read_shift;
        n_write_count  = r_write_count;
        n_write_shift  = r_write_shift;
        n_write_target = r_write_target;
        n_write_enable = r_write_enable;
        n_out_level    = eff_out_level;
        n_rd_load      = 1'b0;
        item_we        = 1'b0;
        item_waddr     = cmd_addr;
        item_wdata     = ERASED_WORD;
        item_re        = 1'b0;
        item_raddr     = cmd_addr;
        if (!pin_cs) begin
            n_cmd_count   = '0;
            n_cmd_shift   = '0;
            n_read_count  = '0;
            n_write_count = '0;
            n_out_level   = 1'b1;
        end else if (rise) begin
            if (r_read_count != '0) begin
                // Shift out read data, MSB first
                n_out_level  = eff_read_shift[WORD_W-1];
                n_read_shift = {eff_read_shift[WORD_W-2:0], 1'b0};
                n_read_count = r_read_count - WCNT_W'(1);
            end else if (r_write_count != '0) begin
                // Shift in write data, store on the last bit if writes are enabled
                n_write_shift = {r_write_shift[WORD_W-2:0], pin_di};
                n_write_count = r_write_count - WCNT_W'(1);
                if (r_write_count == WCNT_W'(1) && r_write_enable) begin
                    item_we    = 1'b1;
                    item_waddr = r_write_target;
                    item_wdata = {r_write_shift[WORD_W-2:0], pin_di};
                end
            end else if (r_cmd_count != '0 || pin_di) begin
                // Collect start, opcode and address bits, then decode the command
                n_cmd_shift = cmd_next;
                n_cmd_count = r_cmd_count + CCNT_W'(1);
                if (r_cmd_count == CCNT_W'(CMD_BITS - 1)) begin
                    n_cmd_shift = '0;
                    n_cmd_count = '0;
                    case (cmd_op)
                        OP_READ: begin
                            item_re      = 1'b1;
                            n_rd_load    = 1'b1;
                            n_read_count = WORD_LEN;
                        end
                        OP_WRITE: begin
                            n_write_target = cmd_addr;
                            n_write_shift  = '0;
                            n_write_count  = WORD_LEN;
                        end
                        OP_ERASE: begin
                            item_we = r_write_enable;
                        end
                        default: begin
                            if (cmd_ctl == CTL_EWEN) begin
                                n_write_enable = 1'b1;
                            end else if (cmd_ctl == CTL_EWDS) begin
                                n_write_enable = 1'b0;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Share the write port between the erase pass and commands
    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = ERASED_WORD;
        end else begin
            ram_we    = in_accept && item_we;
            ram_waddr = item_waddr;
            ram_wdata = item_wdata;
        end
    end

    mse_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept && item_re),
        .i_raddr (item_raddr),
        .o_rdata (ram_rdata)
    );

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy     <= 1'b1;
            r_clr_addr     <= '0;
            r_out_valid    <= 1'b0;
            r_clock_before <= 1'b0;
            r_cmd_count    <= '0;
            r_read_count   <= '0;
            r_write_count  <= '0;
            r_write_enable <= 1'b0;
            r_out_level    <= 1'b1;
            r_rd_load      <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + ADDRESS_BITS'(1);
                if (&r_clr_addr) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_accept) begin
                r_out_valid    <= 1'b1;
                r_clock_before <= n_clock_before;
                r_cmd_count    <= n_cmd_count;
                r_read_count   <= n_read_count;
                r_write_count  <= n_write_count;
                r_write_enable <= n_write_enable;
                r_out_level    <= n_out_level;
                r_rd_load      <= n_rd_load;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Advance payload state
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd_shift    <= n_cmd_shift;
            r_read_shift   <= n_read_shift;
            r_write_shift  <= n_write_shift;
            r_write_target <= n_write_target;
        end
    end

    // Hold the pin layout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_layout <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_PIN_LAYOUT) begin
            r_pin_layout <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PIN_LAYOUT) ? {31'b0, r_pin_layout} : 32'b0;

    // Show the line state after the last transfer
    assign o_out_valid      = r_out_valid;
    assign o_data_out       = eff_out_level;
    assign o_writes_allowed = r_write_enable;

    `MSE_ASSERT(a_no_accept_in_clear, i_clk, i_rst_n, r_clr_busy |-> !o_in_ready, "input taken during erase pass")
    `MSE_ASSERT(a_read_write_excl, i_clk, i_rst_n, !(r_read_count != '0 && r_write_count != '0), "read and write data phases overlap")
    `MSE_ASSERT(a_rd_load_full, i_clk, i_rst_n, r_rd_load |-> (r_read_count == WORD_LEN), "pending read load without a full read count")
    `MSE_ASSERT(a_accept_gives_result, i_clk, i_rst_n, in_accept |=> o_out_valid, "accepted transfer gives no result")

endmodule

FILE: tb/eeprom_response_checker.sv
`timescale 1ns / 1ps
module eeprom_response_checker
    import mse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_port_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_data_out,
    input  logic        i_writes_allowed,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_pending,
    output int          o_mismatches
);

    localparam int ADDR_W = ADDRESS_BITS_DEF;
    localparam int CMD_W  = ADDR_W + 3;
    localparam int DEPTH  = 1 << ADDR_W;

    typedef struct packed {
        logic data_out;
        logic writes_allowed;
    } t_line_levels;

    // Shadow copy of the serial EEPROM
    logic [WORD_W-1:0] word_mem [DEPTH];
    logic              clk_seen;
    logic [CMD_W-1:0]  cmd_bits;
    int                cmd_taken;
    logic [WORD_W-1:0] read_word;
    int                read_left;
    logic [WORD_W-1:0] write_word;
    int                write_left;
    logic [ADDR_W-1:0] write_addr;
    logic              program_en;
    logic              dout_level;
    logic              layout;

    t_line_levels expected_levels[$];
    int           mismatch_count = 0;
    int           pending_count  = 0;

    assign o_pending    = pending_count;
    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic clear_shadow();
        for (int i = 0; i < DEPTH; i++) begin
            word_mem[i] = ERASED_WORD;
        end
        clk_seen   = 1'b0;
        cmd_bits   = '0;
        cmd_taken  = 0;
        read_word  = '0;
        read_left  = 0;
        write_word = '0;
        write_left = 0;
        write_addr = '0;
        program_en = 1'b0;
        dout_level = 1'b1;
        layout     = 1'b0;
    endtask

    // Execute a complete start + opcode + address frame
    task automatic execute_command();
        t_opcode           op;
        t_control          ctl;
        logic [ADDR_W-1:0] addr;
        op   = t_opcode'(cmd_bits[ADDR_W+1 -: 2]);
        addr = cmd_bits[ADDR_W-1:0];
        ctl  = t_control'(addr[ADDR_W-1 -: 2]);
        case (op)
            OP_READ: begin
                read_word  = word_mem[addr];
                read_left  = WORD_W;
                dout_level = read_word[WORD_W-1];
            end
            OP_WRITE: begin
                write_addr = addr;
                write_word = '0;
                write_left = WORD_W;
            end
            OP_ERASE: begin
                if (program_en) begin
                    word_mem[addr] = ERASED_WORD;
                end
            end
            default: begin
                // ERAL and WRAL fall through untouched
                if (ctl == CTL_EWEN) begin
                    program_en = 1'b1;
                end else if (ctl == CTL_EWDS) begin
                    program_en = 1'b0;
                end
            end
        endcase
        cmd_bits  = '0;
        cmd_taken = 0;
    endtask

    // One rising serial clock with select high
    task automatic serial_clock_edge(input logic di);
        if (read_left > 0) begin
            dout_level = read_word[WORD_W-1];
            read_word  = read_word << 1;
            read_left--;
        end else if (write_left > 0) begin
            write_word = {write_word[WORD_W-2:0], di};
            write_left--;
            if (write_left == 0 && program_en) begin
                word_mem[write_addr] = write_word;
            end
        end else if (cmd_taken != 0 || di) begin
            // Zeros ahead of the start bit are dropped
            cmd_bits = {cmd_bits[CMD_W-2:0], di};
            cmd_taken++;
            if (cmd_taken == CMD_W) begin
                execute_command();
            end
        end
    endtask

    task automatic predict_line_levels(input logic [7:0] b, output t_line_levels lv);
        logic clk;
        logic cs;
        logic di;
        clk = layout ? b[PIN1_CLK] : b[PIN0_CLK];
        cs  = layout ? b[PIN1_CS]  : b[PIN0_CS];
        di  = layout ? b[PIN1_DI]  : b[PIN0_DI];
        if (!cs) begin
            cmd_bits   = '0;
            cmd_taken  = 0;
            read_left  = 0;
            write_left = 0;
            dout_level = 1'b1;
        end else if (!clk_seen && clk) begin
            serial_clock_edge(di);
        end
        clk_seen          = clk;
        lv.data_out       = dout_level;
        lv.writes_allowed = program_en;
    endtask

    // Track register writes, compare results, then predict new transfers
    always @(posedge i_clk) begin : monitor
        t_line_levels want;
        if (!i_rst_n) begin
            clear_shadow();
            expected_levels.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && (i_paddr >> 2) == REG_PIN_LAYOUT) begin
                layout = i_pwdata[0];
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_levels.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding");
                end else begin
                    want = expected_levels.pop_front();
                    if (i_data_out !== want.data_out) begin
                        report_mismatch($sformatf("data_out: expected %0b, got %0b",
                                                  want.data_out, i_data_out));
                    end
                    if (i_writes_allowed !== want.writes_allowed) begin
                        report_mismatch($sformatf("writes_allowed: expected %0b, got %0b",
                                                  want.writes_allowed, i_writes_allowed));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_line_levels(i_port_byte, want);
                expected_levels.push_back(want);
            end
        end
        pending_count = expected_levels.size();
    end

endmodule

FILE: tb/tb_microwire_serial_eeprom.sv
`timescale 1ns / 1ps
module tb_microwire_serial_eeprom;
    import mse_pkg::*;

    localparam int ADDR_W      = ADDRESS_BITS_DEF;
    localparam int CMD_W       = ADDR_W + 3;
    localparam int LIMIT       = 600000;
    localparam int ITEM_TARGET = 1950;
    localparam int PHASES      = 4;

    localparam logic [2:0] PIN_LAYOUT_ADDR = {REG_PIN_LAYOUT, 2'b00};
    localparam logic [2:0] UNUSED_ADDR     = 3'd4;

    // Receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_HOLD   = 3;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_port_byte = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = 3'd0;
    logic [31:0] pwdata      = 32'd0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_data_out;
    logic        o_writes_allowed;
    logic [31:0] prdata;
    logic        pready;

    int   pending;
    int   mismatches;
    logic layout_now = 1'b0;
    int   sent       = 0;
    int   burst_left = 0;
    int   rx_mode    = RX_OPEN;
    int   rx_left    = 0;
    int   rx_tick    = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    microwire_serial_eeprom u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_port_byte     (i_port_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_data_out      (o_data_out),
        .o_writes_allowed(o_writes_allowed),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    eeprom_response_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_port_byte     (i_port_byte),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_data_out      (o_data_out),
        .i_writes_allowed(o_writes_allowed),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_pending       (pending),
        .o_mismatches    (mismatches)
    );

    // Result-side backpressure: switch pattern every so often
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_OPEN, RX_HOLD);
            rx_left = $urandom_range(16, 160);
            rx_tick = 0;
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_out_ready <= (rx_tick % 4 == 0);
            default:   i_out_ready <= (rx_tick % 17 == 0);
        endcase
    end

    // Hold one port byte until its transfer; open a new burst, sometimes after a gap
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_port_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        sent++;
    endtask

    // Drop valid and wait until every result has been taken
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Place the three serial lines; the other bits carry noise
    function automatic logic [7:0] pin_byte(input logic clk, input logic cs, input logic di);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (layout_now) begin
            b[PIN1_CLK] = clk;
            b[PIN1_CS]  = cs;
            b[PIN1_DI]  = di;
        end else begin
            b[PIN0_CLK] = clk;
            b[PIN0_CS]  = cs;
            b[PIN0_DI]  = di;
        end
        return b;
    endfunction

    // Low phase, rising phase, and now and then a held-high phase with data moving
    task automatic clock_bit(input logic di);
        send_byte(pin_byte(1'b0, 1'b1, 1'($urandom_range(0, 1))));
        send_byte(pin_byte(1'b1, 1'b1, di));
        if ($urandom_range(0, 7) == 0) begin
            send_byte(pin_byte(1'b1, 1'b1, 1'($urandom_range(0, 1))));
        end
    endtask

    task automatic deselect();
        repeat ($urandom_range(1, 2)) begin
            send_byte(pin_byte(1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1))));
        end
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ERASED_WORD;
            2:       return 16'h8000;
            3:       return 16'h0001;
            default: return WORD_W'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    // Favor the two ends of the store so reads meet earlier writes
    function automatic logic [ADDR_W-1:0] pick_addr();
        if ($urandom_range(0, 2) == 0) begin
            return ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
        end
        if ($urandom_range(0, 1) == 0) begin
            return ADDR_W'($urandom_range(0, 1));
        end
        return ADDR_W'((1 << ADDR_W) - 2 + $urandom_range(0, 1));
    endfunction

    function automatic logic [ADDR_W-1:0] control_addr();
        t_control          ctl;
        logic [ADDR_W-3:0] low;
        int                r;
        r   = $urandom_range(0, 99);
        low = (ADDR_W - 2)'($urandom_range(0, (1 << (ADDR_W - 2)) - 1));
        if (r < 60) begin
            ctl = CTL_EWEN;
        end else if (r < 75) begin
            ctl = CTL_EWDS;
        end else if (r < 88) begin
            ctl = CTL_ERAL;
        end else begin
            ctl = CTL_WRAL;
        end
        return {ctl, low};
    endfunction

    // Clock out one frame, optionally cut short, then drop select
    task automatic run_command(input t_opcode op, input logic [ADDR_W-1:0] addr, input int cut);
        logic              frame[$];
        logic [WORD_W-1:0] data;
        int                n;
        repeat ($urandom_range(0, 2)) frame.push_back(1'b0);
        frame.push_back(1'b1);
        frame.push_back(op[1]);
        frame.push_back(op[0]);
        for (int i = ADDR_W - 1; i >= 0; i--) begin
            frame.push_back(addr[i]);
        end
        if (op == OP_WRITE || op == OP_READ) begin
            data = pick_word();
            for (int i = WORD_W - 1; i >= 0; i--) begin
                frame.push_back(data[i]);
            end
        end
        n = (cut >= 0 && cut < frame.size()) ? cut : frame.size();
        for (int i = 0; i < n; i++) begin
            clock_bit(frame[i]);
        end
        deselect();
    endtask

    // Short hand-made opening on the default layout
    task automatic run_directed();
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h80);
        send_byte(8'hc0);
        send_byte(8'h40);
        send_byte(8'hc0);
        run_command(OP_MISC, {CTL_EWEN, 4'b1010}, -1);
    endtask

    task automatic run_random(input int upto);
        int kind;
        while (sent < upto) begin
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end else if (kind < 18) begin
                run_command(OP_MISC, control_addr(), -1);
            end else if (kind < 44) begin
                run_command(OP_WRITE, pick_addr(), -1);
            end else if (kind < 72) begin
                run_command(OP_READ, pick_addr(), -1);
            end else if (kind < 82) begin
                run_command(OP_ERASE, pick_addr(), -1);
            end else if (kind < 98) begin
                run_command(t_opcode'($urandom_range(0, 3)), pick_addr(),
                            $urandom_range(1, CMD_W + WORD_W - 1));
            end else begin
                wait_drained();
            end
        end
    endtask

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] reg_value;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Hold off while the store is being erased
        do @(negedge i_clk); while (!o_in_ready);
        for (int phase = 0; phase < PHASES; phase++) begin
            layout_now = phase[0];
            reg_value = $urandom();
            reg_value[0] = layout_now;
            apb_write(PIN_LAYOUT_ADDR, reg_value);
            if (phase == 2) begin
                apb_write(UNUSED_ADDR, $urandom());
            end
            if (phase == 0) begin
                run_directed();
            end
            run_random((phase + 1) * ITEM_TARGET / PHASES);
            wait_drained();
            repeat (4) @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mse_pkg.sv
hw/rtl/mse_ram.sv
hw/rtl/microwire_serial_eeprom.sv
tb/eeprom_response_checker.sv
tb/tb_microwire_serial_eeprom.sv
